// ===== rtl/utf8_text_cell_placer_top_macros.svh =====
// assertion macros for the utf8 text cell placer
// used by utf8_text_cell_placer_top; no other dependencies
`ifndef UTF8_TEXT_CELL_PLACER_TOP_MACROS_SVH
`define UTF8_TEXT_CELL_PLACER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define UTCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define UTCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/utcp_pkg.sv =====
// shared types, constants and decode helpers for the utf8 text cell placer
// no dependencies
`default_nettype none

package utcp_pkg;

    localparam int MAX_COLUMNS = 16;
    localparam int MAX_ROWS    = 8;

    localparam int COLS_W  = 5;
    localparam int ROWS_W  = 4;
    localparam int SCOL_W  = 4;
    localparam int SROW_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int CELL_W  = 7;
    localparam int GLYPH_W = 16;
    localparam int ACC_W   = 32;
    localparam int LEFT_W  = 3;
    localparam int COL_W   = 5;
    localparam int ROW_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [COLS_W-1:0] COLS_RESET = 5'd12;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 4'd2;

    localparam logic [ACC_W-1:0] GLYPH_BASE = 32'h0000_0020;
    localparam logic [ACC_W-1:0] CODE_MAX   = 32'h0000_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEXT_COLUMNS = 1'b0,
        CFG_TEXT_ROWS    = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic              start_req;
        logic [SCOL_W-1:0] start_column;
        logic [SROW_W-1:0] start_row;
        logic [BYTE_W-1:0] data_byte;
    } t_item;

    typedef struct packed {
        logic               write_valid;
        logic [CELL_W-1:0]  cell_index;
        logic [GLYPH_W-1:0] glyph_code;
        logic               ended;
    } t_result;

    // screen size after clamping to the supported maximum
    typedef struct packed {
        logic [COLS_W-1:0] eff_columns;
        logic [ROWS_W-1:0] eff_rows;
    } t_cfg;

    function automatic logic [LEFT_W-1:0] trailing_count(input logic [BYTE_W-1:0] b);
        logic [LEFT_W-1:0] n;
        if (b >= 8'hFC)      n = 3'd5;
        else if (b >= 8'hF8) n = 3'd4;
        else if (b >= 8'hF0) n = 3'd3;
        else if (b >= 8'hE0) n = 3'd2;
        else if (b >= 8'hC0) n = 3'd1;
        else                 n = 3'd0;
        return n;
    endfunction

    // offset left behind by the lead-byte marker bits of each length
    function automatic logic [ACC_W-1:0] len_offset(input logic [LEFT_W-1:0] cls);
        logic [ACC_W-1:0] v;
        case (cls)
            3'd1:    v = 32'h0000_3080;
            3'd2:    v = 32'h000E_2080;
            3'd3:    v = 32'h03C8_2080;
            3'd4:    v = 32'hFA08_2080;
            3'd5:    v = 32'h8208_2080;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/utcp_ifs.sv =====
// valid/ready channel interfaces for input bytes and cell writes
// depends on utcp_pkg
`default_nettype none

interface utcp_item_if
    import utcp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              start_req;
    logic [SCOL_W-1:0] start_column;
    logic [SROW_W-1:0] start_row;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, start_req, start_column, start_row, data_byte,
                    input ready);
    modport sink   (input valid, start_req, start_column, start_row, data_byte,
                    output ready);
endinterface

interface utcp_result_if
    import utcp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               write_valid;
    logic [CELL_W-1:0]  cell_index;
    logic [GLYPH_W-1:0] glyph_code;
    logic               ended;

    modport source (output valid, write_valid, cell_index, glyph_code, ended,
                    input ready);
    modport sink   (input valid, write_valid, cell_index, glyph_code, ended,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/utcp_in_stage.sv =====
// input register: takes one byte transfer per cycle into a holding stage while it is empty or being advanced
// depends on utcp_pkg and utcp_item_if
`default_nettype none

module utcp_in_stage
    import utcp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    utcp_item_if.sink  i_item,
    input  wire logic  i_advance,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  accept;

    assign i_item.ready = !r_valid || i_advance;
    assign accept       = i_item.valid && i_item.ready;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.start_req    <= i_item.start_req;
            r_item.start_column <= i_item.start_column;
            r_item.start_row    <= i_item.start_row;
            r_item.data_byte    <= i_item.data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== rtl/utcp_core.sv =====
// utf8 decode and cell placement for one byte, plus the string state
// depends on utcp_pkg
`default_nettype none

module utcp_core
    import utcp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_advance,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_result    o_result
);

    logic              r_active,  n_active;
    logic [COL_W-1:0]  r_col,     n_col;
    logic [ROW_W-1:0]  r_row,     n_row;
    logic [ACC_W-1:0]  r_acc,     n_acc;
    logic [LEFT_W-1:0] r_left,    n_left;
    logic [LEFT_W-1:0] r_class,   n_class;

    logic             go;
    logic             finish;
    logic             bad_start;
    logic [ACC_W-1:0] code;
    logic [7:0]       cell_addr;
    t_result          res;

    always_comb begin
        n_active = r_active;
        n_col    = r_col;
        n_row    = r_row;
        n_acc    = r_acc;
        n_left   = r_left;
        n_class  = r_class;
        res      = '0;
        finish   = 1'b0;
        go       = r_active;

        bad_start = ({1'b0, i_item.start_column} >= i_cfg.eff_columns)
                 || ({1'b0, i_item.start_row} >= i_cfg.eff_rows);

        if (i_item.start_req) begin
            // a start drops any partial character
            n_left  = '0;
            n_class = '0;
            n_acc   = '0;
            if (bad_start) begin
                n_active  = 1'b0;
                res.ended = 1'b1;
                go        = 1'b0;
            end else begin
                n_active = 1'b1;
                n_col    = {1'b0, i_item.start_column};
                n_row    = i_item.start_row;
                go       = 1'b1;
            end
        end

        if (go) begin
            if (n_left != '0) begin
                // trailing byte, taken raw
                n_acc  = (n_acc << 6) + ACC_W'(i_item.data_byte);
                n_left = n_left - 3'd1;
                finish = (n_left == '0);
            end else if (i_item.data_byte == '0 || n_col >= i_cfg.eff_columns) begin
                n_active  = 1'b0;
                res.ended = 1'b1;
            end else begin
                n_acc   = ACC_W'(i_item.data_byte);
                n_class = trailing_count(i_item.data_byte);
                n_left  = n_class;
                finish  = (n_left == '0);
            end
        end

        code      = n_acc - len_offset(n_class);
        cell_addr = 8'(n_row) * 8'(i_cfg.eff_columns) + 8'(n_col);

        if (finish) begin
            res.write_valid = 1'b1;
            res.cell_index  = cell_addr[CELL_W-1:0];
            if (code < GLYPH_BASE || code > CODE_MAX) begin
                res.glyph_code = '0;
            end else begin
                res.glyph_code = GLYPH_W'(code - GLYPH_BASE);
            end
            n_col  = n_col + 5'd1;
            n_left = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_acc    <= '0;
            r_left   <= '0;
            r_class  <= '0;
        end else if (i_advance) begin
            r_active <= n_active;
            r_col    <= n_col;
            r_row    <= n_row;
            r_acc    <= n_acc;
            r_left   <= n_left;
            r_class  <= n_class;
        end
    end

    assign o_result = res;

endmodule

`default_nettype wire

// ===== rtl/utcp_out_stage.sv =====
// result register driving the cell write channel
// depends on utcp_pkg and utcp_result_if
`default_nettype none

module utcp_out_stage
    import utcp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_load,
    input  wire t_result  i_result,
    utcp_result_if.source o_result,
    output logic          o_free
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free = !r_valid || o_result.ready;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_result.ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_result.valid       = r_valid;
    assign o_result.write_valid = r_res.write_valid;
    assign o_result.cell_index  = r_res.cell_index;
    assign o_result.glyph_code  = r_res.glyph_code;
    assign o_result.ended       = r_res.ended;

endmodule

`default_nettype wire

// ===== rtl/utf8_text_cell_placer_top.sv =====
// utf8 text cell placer: byte input stage, decode core, result stage, config
// depends on utcp_pkg, utcp_ifs, utcp_in_stage, utcp_core, utcp_out_stage
//
// Usage: bytes of a string arrive on i_item as valid/ready transfers; the byte
// flagged start_req carries the start column and row. Every input transfer
// gives exactly one result transfer on o_result: a cell write (write_valid,
// cell_index, glyph_code), an end-of-string flag (ended), or all zeros for any
// other byte.
// A result passes through the input register, then the result register,
// and is presented on o_result from the result register. Throughput: one
// byte per cycle while the receiver takes results; the decode between the
// two registers is combinational.
// When the receiver stalls, the result register holds and the input
// register keeps one more byte; ready drops only when both are full.
// Reset clears both stages, the string state, and sets the screen to
// 12 columns by 2 rows. i_cfg_we writes text_columns (index 0) or
// text_rows (index 1) and should only be used while the block is idle.
// There is no memory to clear after reset.
`default_nettype none

module utf8_text_cell_placer_top
    import utcp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    utcp_item_if.sink                  i_item,
    utcp_result_if.source              o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "utf8_text_cell_placer_top_macros.svh"

    logic [COLS_W-1:0] r_text_columns;
    logic [ROWS_W-1:0] r_text_rows;

    t_cfg    cfg;
    logic    in_valid;
    t_item   in_item;
    logic    out_free;
    logic    advance;
    t_result core_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_columns <= COLS_RESET;
            r_text_rows    <= ROWS_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_TEXT_COLUMNS: r_text_columns <= i_cfg_data[COLS_W-1:0];
                CFG_TEXT_ROWS:    r_text_rows    <= i_cfg_data[ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp the screen to what the placer supports
    assign cfg.eff_columns = (int'(r_text_columns) > MAX_COLUMNS)
                           ? COLS_W'(MAX_COLUMNS) : r_text_columns;
    assign cfg.eff_rows    = (int'(r_text_rows) > MAX_ROWS)
                           ? ROWS_W'(MAX_ROWS) : r_text_rows;

    assign advance = in_valid && out_free;

    utcp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    utcp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (in_item),
        .i_cfg     (cfg),
        .o_result  (core_res)
    );

    utcp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (core_res),
        .o_result (o_result),
        .o_free   (out_free)
    );

    // input backpressure only when both stages are full and the output stalls
    `UTCP_ASSERT_NOW(a_ready_only_when_full, i_clk, i_rst_n, !i_item.ready,
        in_valid && o_result.valid && !o_result.ready, "input stalled without cause")

    // a held byte that finds the result stage free shows up as a result
    `UTCP_ASSERT_NEXT(a_stage_moves, i_clk, i_rst_n, in_valid && out_free,
        o_result.valid, "byte lost between stages")

    // a cell write never also flags the end of the string
    `UTCP_ASSERT_NOW(a_write_not_ended, i_clk, i_rst_n,
        o_result.valid && o_result.write_valid, !o_result.ended,
        "write and end in one result")

    // a column write lands in the register
    `UTCP_ASSERT_NEXT(a_cfg_columns, i_clk, i_rst_n,
        i_cfg_we && (i_cfg_index == CFG_TEXT_COLUMNS),
        r_text_columns == $past(i_cfg_data[COLS_W-1:0]), "column write lost")

endmodule

`default_nettype wire

// ===== verif/tb_utf8_text_cell_placer_top.sv =====
`timescale 1ns / 1ps
// testbench for utf8_text_cell_placer_top: directed and random byte strings,
// predicted results checked in order against the result channel
// depends on utcp_pkg, utcp_ifs and the rtl of the block

module tb_utf8_text_cell_placer_top;
    import utcp_pkg::*;

    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int IDLE_PCT        = 33;
    localparam int ITEMS_PER_PHASE = 290;
    localparam int CALM_FROM       = 700;
    localparam int CALM_TO         = 1000;
    localparam int RX_HOLD         = 80;
    localparam int PRINT_CAP       = 60;
    localparam int NUM_PHASES      = 6;

    // marker bits left in the accumulator by the lead byte of each length
    localparam logic [ACC_W-1:0] MARKER_OFFSET [6] = '{
        32'h0000_0000, 32'h0000_3080, 32'h000E_2080,
        32'h03C8_2080, 32'hFA08_2080, 32'h8208_2080
    };

    class cell_write_scoreboard;
        t_result        want_q[$];
        int             errors;
        int             scr_cols;
        int             scr_rows;
        bit             in_string;
        logic [4:0]     cursor_col;
        logic [2:0]     cursor_row;
        logic [31:0]    code_acc;
        logic [2:0]     trail_left;
        logic [2:0]     trail_total;

        function new();
            errors      = 0;
            scr_cols    = int'(COLS_RESET);
            scr_rows    = int'(ROWS_RESET);
            in_string   = 1'b0;
            cursor_col  = '0;
            cursor_row  = '0;
            code_acc    = '0;
            trail_left  = '0;
            trail_total = '0;
        endfunction

        function void set_register(t_cfg_index idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_TEXT_COLUMNS) begin
                scr_cols = int'(val[4:0]);
            end else begin
                scr_rows = int'(val[3:0]);
            end
        endfunction

        function int cols_eff();
            return (scr_cols > MAX_COLUMNS) ? MAX_COLUMNS : scr_cols;
        endfunction

        function int rows_eff();
            return (scr_rows > MAX_ROWS) ? MAX_ROWS : scr_rows;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function logic [2:0] lead_trail_count(logic [7:0] b);
            if (b >= 8'hFC) return 3'd5;
            if (b >= 8'hF8) return 3'd4;
            if (b >= 8'hF0) return 3'd3;
            if (b >= 8'hE0) return 3'd2;
            if (b >= 8'hC0) return 3'd1;
            return 3'd0;
        endfunction

        function void finish_glyph(inout t_result r);
            logic [31:0] cp;
            int          cell_no;
            cp = code_acc - MARKER_OFFSET[trail_total];
            r.write_valid = 1'b1;
            r.glyph_code  = (cp < 32'h20 || cp > 32'hFFFF) ? 16'h0000 : 16'(cp - 32'h20);
            cell_no       = int'(cursor_row) * cols_eff() + int'(cursor_col);
            r.cell_index  = 7'(cell_no);
            cursor_col    = cursor_col + 5'd1;
            trail_left    = '0;
        endfunction

        function t_result decode_byte(t_item it);
            t_result r;
            r = '0;
            if (it.start_req) begin
                trail_left  = '0;
                trail_total = '0;
                code_acc    = '0;
                if (int'(it.start_column) >= cols_eff() || int'(it.start_row) >= rows_eff()) begin
                    in_string = 1'b0;
                    r.ended   = 1'b1;
                    return r;
                end
                in_string  = 1'b1;
                cursor_col = {1'b0, it.start_column};
                cursor_row = it.start_row;
            end
            if (!in_string) return r;
            if (trail_left != 0) begin
                code_acc   = (code_acc << 6) + {24'h0, it.data_byte};
                trail_left = trail_left - 3'd1;
                if (trail_left == 0) finish_glyph(r);
                return r;
            end
            // lead byte: NUL or a full row closes the string
            if (it.data_byte == 8'h00 || int'(cursor_col) >= cols_eff()) begin
                in_string = 1'b0;
                r.ended   = 1'b1;
                return r;
            end
            code_acc    = {24'h0, it.data_byte};
            trail_total = lead_trail_count(it.data_byte);
            trail_left  = trail_total;
            if (trail_left == 0) finish_glyph(r);
            return r;
        endfunction

        function void note_item(t_item it);
            want_q.push_back(decode_byte(it));
        endfunction

        task report(string msg);
            errors++;
            // keep the log short on a badly broken block
            if (errors <= PRINT_CAP) $display("mismatch: %s", msg);
        endtask

        task check_result(t_result got);
            t_result want;
            if (want_q.size() == 0) begin
                report($sformatf("result with nothing expected: %p", got));
                return;
            end
            want = want_q.pop_front();
            if (got.write_valid !== want.write_valid)
                report($sformatf("write_valid got %0d want %0d", got.write_valid,
                                 want.write_valid));
            if (got.cell_index !== want.cell_index)
                report($sformatf("cell_index got %0d want %0d", got.cell_index,
                                 want.cell_index));
            if (got.glyph_code !== want.glyph_code)
                report($sformatf("glyph_code got %h want %h", got.glyph_code,
                                 want.glyph_code));
            if (got.ended !== want.ended)
                report($sformatf("ended got %0d want %0d", got.ended, want.ended));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    utcp_item_if   item_ch ();
    utcp_result_if res_ch ();

    cell_write_scoreboard sb = new();

    int sent_count = 0;
    int rx_count   = 0;
    int hold_left  = 0;
    int idle_cycles = 0;
    int phase_cols [NUM_PHASES] = '{16, 1, 31, 7, 0, 12};
    int phase_rows [NUM_PHASES] = '{8, 1, 31, 5, 0, 2};
    int phase_end;

    utf8_text_cell_placer_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .o_result    (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    task automatic send_item(input t_item it);
        while (!(sent_count >= CALM_FROM && sent_count < CALM_TO) &&
               $urandom_range(0, 99) < IDLE_PCT) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.start_req    <= it.start_req;
        item_ch.start_column <= it.start_column;
        item_ch.start_row    <= it.start_row;
        item_ch.data_byte    <= it.data_byte;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        sb.note_item(it);
        sent_count++;
    endtask

    task automatic put_start(input int col, input int row, input logic [7:0] b);
        t_item it;
        it.start_req    = 1'b1;
        it.start_column = 4'(col);
        it.start_row    = 3'(row);
        it.data_byte    = b;
        send_item(it);
    endtask

    // start position bits are don't-care here, so they get random values
    task automatic put_byte(input logic [7:0] b);
        t_item it;
        it.start_req    = 1'b0;
        it.start_column = 4'($urandom_range(0, 15));
        it.start_row    = 3'($urandom_range(0, 7));
        it.data_byte    = b;
        send_item(it);
    endtask

    // hold the input off until every predicted result has come back
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_screen(input int cols, input int rows);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TEXT_COLUMNS;
        i_cfg_data  <= CFG_DATA_W'(cols);
        @(posedge i_clk);
        sb.set_register(CFG_TEXT_COLUMNS, CFG_DATA_W'(cols));
        i_cfg_index <= CFG_TEXT_ROWS;
        i_cfg_data  <= CFG_DATA_W'(rows);
        @(posedge i_clk);
        sb.set_register(CFG_TEXT_ROWS, CFG_DATA_W'(rows));
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] pick_lead();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40) return 8'($urandom_range(8'h20, 8'h7F));
        if (k < 45) return 8'($urandom_range(8'h01, 8'h1F));
        if (k < 50) return 8'($urandom_range(8'h80, 8'hBF));
        if (k < 65) return 8'($urandom_range(8'hC0, 8'hDF));
        if (k < 80) return 8'($urandom_range(8'hE0, 8'hEF));
        if (k < 90) return 8'($urandom_range(8'hF0, 8'hF7));
        if (k < 95) return 8'($urandom_range(8'hF8, 8'hFB));
        return 8'($urandom_range(8'hFC, 8'hFF));
    endfunction

    // one string: mostly well formed with random content, some noise,
    // restarts part way through a character and runs past the row end
    task automatic random_string();
        int          ec;
        int          er;
        int          col;
        int          row;
        int          nchars;
        int          tail;
        logic [7:0]  lead;
        logic [2:0]  ntrail;
        t_item       it;
        ec = sb.cols_eff();
        er = sb.rows_eff();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                it = t_item'(16'($urandom));
                send_item(it);
            end
            return;
        end
        if (ec > 0 && er > 0 && $urandom_range(0, 99) < 90) begin
            col = $urandom_range(0, ec - 1);
            row = $urandom_range(0, er - 1);
        end else begin
            col = $urandom_range(0, 15);
            row = $urandom_range(0, 7);
        end
        nchars = $urandom_range(1, ec + 3);
        for (int c = 0; c < nchars; c++) begin
            lead   = pick_lead();
            ntrail = sb.lead_trail_count(lead);
            if (c == 0) put_start(col, row, lead);
            else        put_byte(lead);
            for (int t = 0; t < int'(ntrail); t++) begin
                if ($urandom_range(0, 49) == 0) return;
                if ($urandom_range(0, 99) < 85) put_byte({2'b10, 6'($urandom_range(0, 63))});
                else                            put_byte(8'($urandom_range(0, 255)));
            end
        end
        tail = $urandom_range(0, 9);
        if (tail < 5) begin
            put_byte(8'h00);
            if (tail == 4) begin
                repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // receiver: random stalls, a calm window, and long hold-offs
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                t_result got;
                got.write_valid = res_ch.write_valid;
                got.cell_index  = res_ch.cell_index;
                got.glyph_code  = res_ch.glyph_code;
                got.ended       = res_ch.ended;
                sb.check_result(got);
                rx_count++;
                if (rx_count == 400 || rx_count == 1300) hold_left = RX_HOLD;
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else if (rx_count >= CALM_FROM && rx_count < CALM_TO) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // watchdog on cycles with no transfer on any port
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_utf8_text_cell_placer_top: done, errors");
        $finish;
    end

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_index          = CFG_TEXT_COLUMNS;
        i_cfg_data           = '0;
        item_ch.valid        = 1'b0;
        item_ch.start_req    = 1'b0;
        item_ch.start_column = '0;
        item_ch.start_row    = '0;
        item_ch.data_byte    = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset screen is 12 x 2
        put_start(0, 0, 8'h1F);
        put_byte(8'hC2);
        put_byte(8'h00);
        put_byte(8'hEF);
        put_byte(8'hBF);
        put_byte(8'hBF);
        put_byte(8'hF8);
        put_byte(8'h88);
        put_byte(8'h80);
        put_byte(8'h80);
        put_byte(8'h80);
        put_byte(8'hFC);
        put_byte(8'h84);
        put_byte(8'h80);
        put_byte(8'h80);
        put_byte(8'h80);
        put_byte(8'h80);
        put_byte(8'hBF);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_start(15, 0, 8'h41);
        put_start(0, 7, 8'h41);
        // last cell, a restart inside a character, then the row runs out
        put_start(11, 1, 8'hE2);
        put_start(11, 1, 8'h7F);
        put_byte(8'h41);

        drain();
        set_screen(0, 8);
        put_start(0, 0, 8'h41);
        drain();
        set_screen(16, 0);
        put_start(3, 0, 8'h41);

        phase_cols[4] = $urandom_range(1, 31);
        phase_rows[4] = $urandom_range(1, 31);
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            set_screen(phase_cols[p], phase_rows[p]);
            phase_end = sent_count + ITEMS_PER_PHASE;
            while (sent_count < phase_end) random_string();
        end

        drain();
        repeat (6) @(posedge i_clk);
        if (sb.pending() != 0) sb.report("expected results left over");
        if (sb.errors == 0) begin
            $display("tb_utf8_text_cell_placer_top: done, clean");
        end else begin
            $display("tb_utf8_text_cell_placer_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== utf8_text_cell_placer_top.f =====
+incdir+rtl
rtl/utcp_pkg.sv
rtl/utcp_ifs.sv
rtl/utcp_in_stage.sv
rtl/utcp_core.sv
rtl/utcp_out_stage.sv
rtl/utf8_text_cell_placer_top.sv
verif/tb_utf8_text_cell_placer_top.sv
